// ----- rtl/sdaf_pkg.sv -----
// Shared types and constants for the signed decimal ASCII formatter.
package sdaf_pkg;

    localparam int VALUE_W    = 15;
    localparam int MAG_W      = 14;
    localparam int REM_TH_W   = 10;
    localparam int REM_HU_W   = 7;
    localparam int DIGIT_W    = 4;
    localparam int CHAR_W     = 8;
    localparam int RUN_LEN    = 5;
    localparam int POS_W      = 3;

    localparam int THOUSAND   = 1000;
    localparam int HUNDRED    = 100;
    localparam int TEN        = 10;

    localparam logic [VALUE_W-1:0] MAX_MAGNITUDE = 15'd9999;
    localparam logic [POS_W-1:0]   LAST_POS      = POS_W'(RUN_LEN - 1);

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;

    typedef logic [RUN_LEN-1:0][CHAR_W-1:0] char_run_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        digit_char = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, d};
    endfunction

endpackage

// ----- rtl/sdaf_convert.sv -----
// Combinational split of a signed value into a five-character ASCII run.
module sdaf_convert
    import sdaf_pkg::*;
(
    input  logic [VALUE_W-1:0] value,
    output char_run_t          run
);

    logic                  negative;
    logic [VALUE_W-1:0]    mag_full;
    logic [MAG_W-1:0]      mag;
    logic [DIGIT_W-1:0]    thou;
    logic [DIGIT_W-1:0]    hund;
    logic [DIGIT_W-1:0]    tens;
    logic [DIGIT_W-1:0]    units;
    logic [REM_TH_W-1:0]   rem_th;
    logic [REM_HU_W-1:0]   rem_hu;
    logic [DIGIT_W-1:0]    rem_te;

    always_comb begin
        negative = value[VALUE_W-1];
        mag_full = negative ? (~value + VALUE_W'(1)) : value;
        if (mag_full > MAX_MAGNITUDE) begin
            mag = MAX_MAGNITUDE[MAG_W-1:0];
        end else begin
            mag = mag_full[MAG_W-1:0];
        end

        thou   = '0;
        rem_th = mag[REM_TH_W-1:0];
        for (int k = 1; k < TEN; k++) begin
            if (mag >= MAG_W'(k * THOUSAND)) begin
                thou   = DIGIT_W'(k);
                rem_th = REM_TH_W'(mag - MAG_W'(k * THOUSAND));
            end
        end

        hund   = '0;
        rem_hu = rem_th[REM_HU_W-1:0];
        for (int k = 1; k < TEN; k++) begin
            if (rem_th >= REM_TH_W'(k * HUNDRED)) begin
                hund   = DIGIT_W'(k);
                rem_hu = REM_HU_W'(rem_th - REM_TH_W'(k * HUNDRED));
            end
        end

        tens   = '0;
        rem_te = rem_hu[DIGIT_W-1:0];
        for (int k = 1; k < TEN; k++) begin
            if (rem_hu >= REM_HU_W'(k * TEN)) begin
                tens   = DIGIT_W'(k);
                rem_te = DIGIT_W'(rem_hu - REM_HU_W'(k * TEN));
            end
        end
        units = rem_te;

        run[0] = negative ? CHAR_MINUS : CHAR_PLUS;
        run[1] = (mag >= MAG_W'(THOUSAND)) ? digit_char(thou) : CHAR_SPACE;
        run[2] = (mag >= MAG_W'(HUNDRED))  ? digit_char(hund) : CHAR_SPACE;
        run[3] = (mag >= MAG_W'(TEN))      ? digit_char(tens) : CHAR_SPACE;
        run[4] = digit_char(units);
    end

endmodule

// ----- rtl/sdaf_serializer.sv -----
// Result register that shifts a five-character run out one character per transaction.
module sdaf_serializer
    import sdaf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              item_valid,
    input  char_run_t         run,
    output logic              item_taken,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CHAR_W-1:0] m_character,
    output logic              m_last
);

    char_run_t         shift_reg, shift_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              busy_reg, busy_next;

    assign m_valid     = busy_reg;
    assign m_character = shift_reg[0];
    assign m_last      = (pos_reg == LAST_POS);
    assign item_taken  = item_valid && (!busy_reg || (m_ready && m_last));

    always_comb begin
        shift_next = shift_reg;
        pos_next   = pos_reg;
        busy_next  = busy_reg;
        if (item_taken) begin
            shift_next = run;
            pos_next   = '0;
            busy_next  = 1'b1;
        end else if (busy_reg && m_ready) begin
            if (m_last) begin
                busy_next = 1'b0;
            end else begin
                shift_next = {CHAR_W'(0), shift_reg[RUN_LEN-1:1]};
                pos_next   = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pos_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            pos_reg  <= pos_next;
        end
        shift_reg <= shift_next;
    end

endmodule

// ----- rtl/signed_decimal_ascii_formatter_top.sv -----
// Top level of the signed decimal ASCII formatter: input register, converter, serializer.
//
// Input channel s_valid/s_ready/s_value carries one 15-bit two's complement value per
// transaction. Output channel m_valid/m_ready/m_character/m_last returns five ASCII
// characters per value: sign ('-' or '+'), thousands, hundreds and tens (blank while
// the magnitude is too small), then the units digit with m_last high. Magnitudes above
// 9999 saturate to 9999.
// The value is registered in the input register, then loaded into the serializer's result
// register, which raises m_valid; a busy serializer holds it in the input register.
// The single-character output port limits the value rate; the input register takes the
// next value while the current run is still draining, and the next run starts the cycle
// after the last character is taken.
// Reset (aresetn low, synchronous) empties the input register and the serializer.
// When m_ready is low the current character holds; the input register holds one
// value behind it and s_ready drops once it is full.
module signed_decimal_ascii_formatter_top
    import sdaf_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [VALUE_W-1:0] s_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [CHAR_W-1:0]  m_character,
    output logic               m_last
);

    logic [VALUE_W-1:0] value_reg, value_next;
    logic               in_valid_reg, in_valid_next;
    logic               item_taken;
    char_run_t          run;

    assign s_ready = !in_valid_reg || item_taken;

    always_comb begin
        value_next    = value_reg;
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            value_next    = s_value;
            in_valid_next = 1'b1;
        end else if (item_taken) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        value_reg <= value_next;
    end

    sdaf_convert u_convert (
        .value (value_reg),
        .run   (run)
    );

    sdaf_serializer u_serializer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_valid  (in_valid_reg),
        .run         (run),
        .item_taken  (item_taken),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last      (m_last)
    );

    a_run_starts_with_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        item_taken |=> m_valid && !m_last &&
            (m_character == CHAR_MINUS || m_character == CHAR_PLUS))
        else $error("run does not start with a sign character");

    a_run_no_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid)
        else $error("gap inside a character run");

    a_pending_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !item_taken |=> in_valid_reg && $stable(value_reg))
        else $error("pending value lost before transfer");

    a_taken_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        item_taken && m_valid |-> m_ready && m_last)
        else $error("new run loaded over an unfinished run");

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for the signed decimal ASCII formatter top level.
module tb;
    import sdaf_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } ascii_char_t;

    typedef struct {
        int                        value;
        bit                        typed;
        logic [RUN_LEN*CHAR_W-1:0] text;
    } value_row_t;

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               s_valid     = 1'b0;
    logic               s_ready;
    logic [VALUE_W-1:0] s_value     = '0;
    logic               m_valid;
    logic               m_ready     = 1'b0;
    logic [CHAR_W-1:0]  m_character;
    logic               m_last;

    ascii_char_t pending_chars[$];
    int          error_count     = 0;
    int          values_sent     = 0;
    int          chars_checked   = 0;
    int          send_idle_pct   = 0;
    int          recv_idle_pct   = 0;
    bit          hold_request    = 1'b0;
    int          hold_left       = 0;

    value_row_t directed_rows [24] = '{
        '{0,      1'b1, "+   0"},
        '{1,      1'b1, "+   1"},
        '{-1,     1'b1, "-   1"},
        '{9,      1'b1, "+   9"},
        '{10,     1'b1, "+  10"},
        '{-10,    1'b1, "-  10"},
        '{99,     1'b1, "+  99"},
        '{100,    1'b1, "+ 100"},
        '{-100,   1'b1, "- 100"},
        '{999,    1'b1, "+ 999"},
        '{1000,   1'b1, "+1000"},
        '{-1000,  1'b1, "-1000"},
        '{1005,   1'b1, "+1005"},
        '{9999,   1'b1, "+9999"},
        '{-9999,  1'b1, "-9999"},
        '{10000,  1'b1, "+9999"},
        '{-10000, 1'b1, "-9999"},
        '{16383,  1'b1, "+9999"},
        '{-16384, 1'b1, "-9999"},
        '{4321,   1'b0, '0},
        '{-807,   1'b0, '0},
        '{50,     1'b0, '0},
        '{-6090,  1'b0, '0},
        '{7,      1'b0, '0}
    };

    signed_decimal_ascii_formatter_top i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last      (m_last)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic char_run_t format_value(input logic [VALUE_W-1:0] v);
        logic        neg;
        int unsigned mag;
        char_run_t   run;
        neg = v[VALUE_W-1];
        mag = neg ? (1 << VALUE_W) - int'(v) : int'(v);
        if (mag > int'(MAX_MAGNITUDE)) begin
            mag = int'(MAX_MAGNITUDE);
        end
        run[0] = neg ? CHAR_MINUS : CHAR_PLUS;
        run[1] = (mag >= THOUSAND) ? CHAR_ZERO + CHAR_W'(mag / THOUSAND) : CHAR_SPACE;
        run[2] = (mag >= HUNDRED) ? CHAR_ZERO + CHAR_W'((mag % THOUSAND) / HUNDRED)
                                  : CHAR_SPACE;
        run[3] = (mag >= TEN) ? CHAR_ZERO + CHAR_W'((mag % HUNDRED) / TEN) : CHAR_SPACE;
        run[4] = CHAR_ZERO + CHAR_W'(mag % TEN);
        return run;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int m;
        case ($urandom_range(7))
            0, 1:    m = $urandom_range(9);
            2:       m = $urandom_range(99);
            3:       m = $urandom_range(999);
            4, 5:    m = $urandom_range(9999);
            6:       return VALUE_W'($urandom);
            default: m = $urandom_range(1) ? int'(MAX_MAGNITUDE) : 16384;
        endcase
        if ($urandom_range(1)) begin
            m = -m;
        end
        return VALUE_W'(m);
    endfunction

    // Call at a falling edge; returns at the falling edge after the transaction.
    task automatic send_value(input logic [VALUE_W-1:0] v, input bit typed,
                              input logic [RUN_LEN*CHAR_W-1:0] text);
        char_run_t   run;
        ascii_char_t item;
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_value <= v;
        do @(posedge aclk); while (!s_ready);
        run = format_value(v);
        for (int i = 0; i < RUN_LEN; i++) begin
            item.character = typed ? text[(RUN_LEN-i)*CHAR_W-1 -: CHAR_W] : run[i];
            item.last      = (i == RUN_LEN - 1);
            pending_chars.push_back(item);
        end
        values_sent++;
        @(negedge aclk);
    endtask

    task automatic drain_pending();
        while (pending_chars.size() != 0) @(posedge aclk);
    endtask

    initial begin
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
    end

    // Receiver: random back-pressure plus one long hold-off on request.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = 80;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        ascii_char_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_chars.size() == 0) begin
                $display("%0t: unexpected character 0x%02h last %0b",
                         $time, m_character, m_last);
                error_count++;
            end else begin
                want = pending_chars.pop_front();
                chars_checked++;
                if (m_character !== want.character) begin
                    $display("%0t: character expected 0x%02h actual 0x%02h",
                             $time, want.character, m_character);
                    error_count++;
                end
                if (m_last !== want.last) begin
                    $display("%0t: last expected %0b actual %0b",
                             $time, want.last, m_last);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #200000;
        $display("tb: errors");
        $finish;
    end

    initial begin
        while (!aresetn) @(posedge aclk);
        @(negedge aclk);

        send_idle_pct = 12;
        recv_idle_pct = 50;
        foreach (directed_rows[i]) begin
            send_value(VALUE_W'(directed_rows[i].value), directed_rows[i].typed,
                       directed_rows[i].text);
        end
        repeat (40) send_value(pick_value(), 1'b0, '0);
        s_valid <= 1'b0;

        drain_pending();
        @(negedge aclk);
        send_idle_pct = 50;
        recv_idle_pct = 12;
        repeat (46) send_value(pick_value(), 1'b0, '0);
        s_valid <= 1'b0;

        @(posedge aclk);
        hold_request = 1'b1;
        @(negedge aclk);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (50) send_value(pick_value(), 1'b0, '0);
        s_valid <= 1'b0;

        drain_pending();
        repeat (20) @(posedge aclk);
        $display("tb: %0d values, %0d characters checked, idle and stall mixes",
                 values_sent, chars_checked);
        $display("tb: saturation, blanking and sign cases plus a long output hold-off");
        if (error_count == 0 && pending_chars.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/sdaf_pkg.sv
rtl/sdaf_convert.sv
rtl/sdaf_serializer.sv
rtl/signed_decimal_ascii_formatter_top.sv
dv/tb.sv
